// File: rtl/tpsp_pkg.sv
// ----------------------------------------------------------------------------
// tpsp_pkg - texture pack stream parser shared definitions
// Phase codes, result kinds, container magic and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package tpsp_pkg;

  // default clamp on the declared texture count
  localparam int MAX_TEXTURES_DEF = 32;

  // "WPACK001", first byte of the stream first
  localparam logic [7:0] MAGIC [8] = '{8'h57, 8'h50, 8'h41, 8'h43,
                                       8'h4B, 8'h30, 8'h30, 8'h31};

  typedef enum logic [3:0] {
    PH_MAGIC   = 4'd0,
    PH_TEXCNT  = 4'd1,
    PH_MESHCNT = 4'd2,
    PH_NAMELEN = 4'd3,
    PH_NAME    = 4'd4,
    PH_WIDTH   = 4'd5,
    PH_HEIGHT  = 4'd6,
    PH_PLEN    = 4'd7,
    PH_PAYLOAD = 4'd8,
    PH_IDLE    = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DESC  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [4:0]  idx;
    logic [15:0] w;
    logic [15:0] h;
    logic [31:0] off;
    logic [31:0] len;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/texture_pack_stream_parser.sv
// ----------------------------------------------------------------------------
// texture_pack_stream_parser - byte-serial texture container parser
// Checks the magic, walks the header and per-texture records, and emits a
// descriptor per texture followed by done, or an error.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------------
//  byte     | byte_valid / byte_stall    | data_byte, final_byte
//  result   | result_valid / result_stall| kind, tex_index, tex_width,
//           |                            | tex_height, payload_offset,
//           |                            | payload_length, last_result
//
// One byte is taken per cycle while byte_stall is low. The parse state updates
// at the accepting edge; the 0..2 requests it causes go into a 4-entry result
// queue the same edge. byte_stall rises only while the queue holds 3 or more
// requests (room for two is always kept), so bytes flow without a stall unless
// the result side stalls or bytes keep producing descriptor+done/error pairs.
// rst is synchronous: it clears the parse state and empties the queue.
// The final byte also returns the parser to its reset state.
// ----------------------------------------------------------------------------
`default_nettype none

module texture_pack_stream_parser #(
  parameter int MAX_TEXTURES = tpsp_pkg::MAX_TEXTURES_DEF
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          byte_valid,
  output logic         byte_stall,
  input  wire  [7:0]   data_byte,
  input  wire          final_byte,
  output logic         result_valid,
  input  wire          result_stall,
  output logic [1:0]   kind,
  output logic [4:0]   tex_index,
  output logic [15:0]  tex_width,
  output logic [15:0]  tex_height,
  output logic [31:0]  payload_offset,
  output logic [31:0]  payload_length,
  output logic         last_result
);

  import tpsp_pkg::*;

  // texture counter width: must hold MAX_TEXTURES itself
  localparam int CW = $clog2(MAX_TEXTURES + 1);

  // parse state
  phase_t          phase,          phase_next;
  logic [2:0]      fbc,            fbc_next;       // byte within field / magic
  logic [31:0]     field_shift,    field_shift_next;
  logic [CW-1:0]   declared_count, declared_count_next;
  logic [CW-1:0]   textures_done,  textures_done_next;
  logic [31:0]     skip_remaining, skip_remaining_next;
  logic [15:0]     held_width,     held_width_next;
  logic [15:0]     held_height,    held_height_next;
  logic [31:0]     stream_offset,  stream_offset_next;
  logic [31:0]     payload_start,  payload_start_next;

  // result queue
  result_t         oq [4];
  logic [1:0]      head;
  logic [2:0]      count;

  logic            byte_accept;
  logic            result_pop;

  // per-byte decode
  logic [31:0]     base;
  logic [31:0]     acc;
  logic [2:0]      fbc_inc;
  logic [2:0]      need;
  logic            field_done;
  logic            err_now;
  logic            fin_tex;
  logic [31:0]     fin_off;
  logic [31:0]     fin_len;
  logic [CW-1:0]   td_inc;
  logic [31:0]     td_wide;
  logic [1:0]      n_res;
  result_t         r0, r1;
  result_t         err_res;

  assign byte_accept  = byte_valid && !byte_stall;
  assign result_valid = (count != 3'd0);
  assign result_pop   = result_valid && !result_stall;
  assign byte_stall   = (count > 3'd2);

  // field collector: little-endian, restarts at byte 0
  always_comb begin
    base = (fbc == 3'd0) ? 32'd0 : field_shift;
    case (fbc[1:0])
      2'd0:    acc = base | {24'd0, data_byte};
      2'd1:    acc = base | {16'd0, data_byte, 8'd0};
      2'd2:    acc = base | {8'd0, data_byte, 16'd0};
      2'd3:    acc = base | {data_byte, 24'd0};
      default: acc = base;
    endcase
    fbc_inc = fbc + 3'd1;
    case (phase)
      PH_TEXCNT, PH_MESHCNT, PH_PLEN: need = 3'd4;
      default:                        need = 3'd2;
    endcase
    field_done = (fbc_inc >= need);
  end

  always_comb begin
    phase_next          = phase;
    fbc_next            = fbc;
    field_shift_next    = field_shift;
    declared_count_next = declared_count;
    textures_done_next  = textures_done;
    skip_remaining_next = skip_remaining;
    held_width_next     = held_width;
    held_height_next    = held_height;
    stream_offset_next  = stream_offset + 32'd1;
    payload_start_next  = payload_start;

    err_now = 1'b0;
    fin_tex = 1'b0;
    fin_off = payload_start;
    fin_len = field_shift;
    n_res   = 2'd0;
    r0      = '0;
    r1      = '0;
    err_res = '0;
    err_res.kind = KIND_ERROR;
    td_inc  = textures_done + CW'(1);
    td_wide = 32'(textures_done);

    case (phase)
      PH_MAGIC: begin
        if (data_byte != MAGIC[fbc]) begin
          err_now    = 1'b1;
          phase_next = PH_IDLE;
        end else if (fbc == 3'd7) begin
          fbc_next   = 3'd0;
          phase_next = PH_TEXCNT;
        end else begin
          fbc_next = fbc_inc;
        end
      end
      PH_TEXCNT, PH_MESHCNT, PH_NAMELEN, PH_WIDTH, PH_HEIGHT, PH_PLEN: begin
        field_shift_next = acc;
        fbc_next         = field_done ? 3'd0 : fbc_inc;
        if (field_done) begin
          case (phase)
            PH_TEXCNT: begin
              declared_count_next = (acc > 32'(MAX_TEXTURES)) ?
                                    CW'(MAX_TEXTURES) : acc[CW-1:0];
              phase_next = PH_MESHCNT;
            end
            PH_MESHCNT: begin
              if (declared_count == '0) begin
                n_res      = 2'd1;
                r0.kind    = KIND_DONE;
                phase_next = PH_IDLE;
              end else begin
                phase_next = PH_NAMELEN;
              end
            end
            PH_NAMELEN: begin
              skip_remaining_next = acc;
              phase_next = (acc != 32'd0) ? PH_NAME : PH_WIDTH;
            end
            PH_WIDTH: begin
              held_width_next = acc[15:0];
              phase_next      = PH_HEIGHT;
            end
            PH_HEIGHT: begin
              held_height_next = acc[15:0];
              phase_next       = PH_PLEN;
            end
            PH_PLEN: begin
              if (held_width == 16'd0 || held_height == 16'd0) begin
                err_now    = 1'b1;
                phase_next = PH_IDLE;
              end else begin
                payload_start_next  = stream_offset + 32'd1;
                skip_remaining_next = acc;
                if (acc == 32'd0) begin
                  // empty payload: describe on the last length byte
                  fin_tex = 1'b1;
                  fin_off = stream_offset + 32'd1;
                  fin_len = acc;
                end else begin
                  phase_next = PH_PAYLOAD;
                end
              end
            end
            default: ;
          endcase
        end
      end
      PH_NAME: begin
        skip_remaining_next = skip_remaining - 32'd1;
        if (skip_remaining_next == 32'd0) phase_next = PH_WIDTH;
      end
      PH_PAYLOAD: begin
        skip_remaining_next = skip_remaining - 32'd1;
        if (skip_remaining_next == 32'd0) fin_tex = 1'b1;
      end
      default: ;
    endcase

    if (err_now) begin
      n_res = 2'd1;
      r0    = err_res;
    end

    if (fin_tex) begin
      n_res              = 2'd1;
      r0.kind            = KIND_DESC;
      r0.idx             = td_wide[4:0];
      r0.w               = held_width;
      r0.h               = held_height;
      r0.off             = fin_off;
      r0.len             = fin_len;
      textures_done_next = td_inc;
      if (td_inc >= declared_count) begin
        n_res      = 2'd2;
        r1.kind    = KIND_DONE;
        phase_next = PH_IDLE;
      end else begin
        phase_next = PH_NAMELEN;
      end
    end

    // end of container: unfinished parse is an error, then back to reset
    if (final_byte) begin
      if (phase_next != PH_IDLE) begin
        if (n_res == 2'd0) r0 = err_res;
        else               r1 = err_res;
        n_res = n_res + 2'd1;
      end
      phase_next          = PH_MAGIC;
      fbc_next            = 3'd0;
      field_shift_next    = 32'd0;
      declared_count_next = '0;
      textures_done_next  = '0;
      skip_remaining_next = 32'd0;
      held_width_next     = 16'd0;
      held_height_next    = 16'd0;
      stream_offset_next  = 32'd0;
      payload_start_next  = 32'd0;
    end

    if (n_res == 2'd1) r0.last = 1'b1;
    if (n_res == 2'd2) r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_MAGIC;
      fbc            <= 3'd0;
      field_shift    <= 32'd0;
      declared_count <= '0;
      textures_done  <= '0;
      skip_remaining <= 32'd0;
      held_width     <= 16'd0;
      held_height    <= 16'd0;
      stream_offset  <= 32'd0;
      payload_start  <= 32'd0;
    end else if (byte_accept) begin
      phase          <= phase_next;
      fbc            <= fbc_next;
      field_shift    <= field_shift_next;
      declared_count <= declared_count_next;
      textures_done  <= textures_done_next;
      skip_remaining <= skip_remaining_next;
      held_width     <= held_width_next;
      held_height    <= held_height_next;
      stream_offset  <= stream_offset_next;
      payload_start  <= payload_start_next;
    end
  end

  // result queue: up to two pushes and one pop per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 2'd0;
      count <= 3'd0;
    end else begin
      if (result_pop) head <= head + 2'd1;
      count <= count - {2'd0, result_pop}
                     + ((byte_accept) ? {1'b0, n_res} : 3'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (byte_accept && n_res != 2'd0) begin
      oq[head + count[1:0]] <= r0;
    end
    if (byte_accept && n_res == 2'd2) begin
      oq[head + count[1:0] + 2'd1] <= r1;
    end
  end

  assign kind           = oq[head].kind;
  assign tex_index      = oq[head].idx;
  assign tex_width      = oq[head].w;
  assign tex_height     = oq[head].h;
  assign payload_offset = oq[head].off;
  assign payload_length = oq[head].len;
  assign last_result    = oq[head].last;

endmodule

`default_nettype wire
